// File: rtl/core/pmps_pkg.sv
// Shared types and constants of the penalized multipath path selector.
package pmps_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int ENTROPY_W = 16;
  localparam int PERM_CFG_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;

  // Penalty increments for congestion marks and negative acknowledgments.
  localparam int ECN_PENALTY = 1;
  localparam int NACK_PENALTY = 4;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_RANDOM_TAG = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_PERM = 1'b1;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_ECN_RD,
    CMD_ECN_WR,
    CMD_NACK_RD,
    CMD_NACK_WR,
    CMD_SW_RD,
    CMD_SW_FIRST,
    CMD_SW_NEXT,
    CMD_EMIT
  } pmps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic sweep_done;
    logic ecn;
    logic nack;
    logic tx;
  } pmps_status_t;

endpackage

// File: rtl/core/penalized_multipath_path_selector.sv
// Top level of the penalized multipath path selector: controller and datapath.
//
// Channel  Dir  Signals                        Contents
// s        in   s_tvalid s_tready s_tdata[31:0] ecn_path, nack_path
//                        s_tuser[2:0]           ecn_event, nack_event, tx_event
// m        out  m_tvalid m_tready m_tdata[15:0] next_path
//                        m_tuser[1:0]           path_valid, status
// cfg      in   cfg_we cfg_addr cfg_wdata       random_tag (0), initial_permutation (1)
//
// After reset a clearing pass writes every entry of the penalty table, with s_tready low.
// An item is routed, then takes an ECN read and write and a NACK read and write where flagged,
// and for a transmit event a sweep: the sweep reads one table entry per cycle from the single
// read port of the penalty memory, so the number of penalized paths in a row sets its length.
// The result waits in an output register; the next beat is accepted while it waits,
// and only a further result stalls until m_tready takes the first.
module penalized_multipath_path_selector #(
  parameter int NUM_PATHS = 256,
  parameter int PENALTY_WIDTH = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0: ecn_path[15:0], nack_path[31:16].
  input  logic [31:0]                      s_tdata,
  // Fields from bit 0: ecn_event, nack_event, tx_event.
  input  logic [2:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0: next_path[15:0].
  output logic [15:0]                      m_tdata,
  // Fields from bit 0: path_valid, status.
  output logic [1:0]                       m_tuser,
  input  logic                             cfg_we,
  input  logic [pmps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pmps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pmps_pkg::*;

  pmps_cmd_t    cmd;
  pmps_status_t status;

  // Sequencer.
  pmps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Table, cursor and result register.
  pmps_datapath #(
    .NUM_PATHS     (NUM_PATHS),
    .PENALTY_WIDTH (PENALTY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_flags  (s_tuser),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_path  (m_tdata),
    .out_flags (m_tuser)
  );

endmodule

// File: rtl/core/pmps_datapath.sv
// Datapath: penalty table memory, cursor, permutation, sweep step logic and result register.
module pmps_datapath #(
  parameter int NUM_PATHS = 256,
  parameter int PENALTY_WIDTH = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pmps_pkg::pmps_cmd_t                  cmd,
  output pmps_pkg::pmps_status_t               status,
  input  logic [2:0]                           in_flags,
  input  logic [2*pmps_pkg::ENTROPY_W-1:0]     in_data,
  input  logic                                 cfg_we,
  input  logic [pmps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pmps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [pmps_pkg::ENTROPY_W-1:0]       out_path,
  output logic [1:0]                           out_flags
);
  import pmps_pkg::*;

  localparam int PW = $clog2(NUM_PATHS);
  localparam int SW = $clog2(NUM_PATHS + 2);
  localparam logic [PW-1:0] IDX_MASK = PW'(NUM_PATHS - 1);
  localparam logic [ENTROPY_W-1:0] IDX_MASK16 = ENTROPY_W'(NUM_PATHS - 1);
  localparam logic [PW:0] NUM_PATHS_EXT = (PW + 1)'(NUM_PATHS);
  localparam logic [PW+3:0] NUM_PATHS_WIDE = (PW + 4)'(NUM_PATHS);
  localparam logic [SW-1:0] STEP_LIMIT = SW'(NUM_PATHS);
  localparam logic [PENALTY_WIDTH-1:0] ECN_INC = PENALTY_WIDTH'(ECN_PENALTY);
  localparam logic [PENALTY_WIDTH-1:0] NACK_INC = PENALTY_WIDTH'(NACK_PENALTY);

  // Permutation reshuffle x -> (5x+1) mod NUM_PATHS; 5x+1 stays below 5*NUM_PATHS.
  function automatic logic [PW-1:0] reshuffle(input logic [PW-1:0] x);
    logic [PW+3:0] v;
    v = ({4'b0, x} << 2) + {4'b0, x} + (PW + 4)'(1);
    for (int i = 0; i < 4; i++) begin
      if (v >= NUM_PATHS_WIDE) begin
        v = v - NUM_PATHS_WIDE;
      end
    end
    return v[PW-1:0] & IDX_MASK;
  endfunction

  // Penalty table and its read-data register.
  logic [PENALTY_WIDTH-1:0] mem [NUM_PATHS];
  logic [PENALTY_WIDTH-1:0] rd_q;
  logic [PW-1:0]            rd_addr;
  logic                     wr_en;
  logic [PW-1:0]            wr_addr;
  logic [PENALTY_WIDTH-1:0] wr_data;
  logic                     byp_valid;
  logic [PENALTY_WIDTH-1:0] byp_data;

  // Selector state and the latched item.
  logic [PW-1:0]            cursor;
  logic [PW-1:0]            perm;
  logic                     initialized;
  logic [SW-1:0]            steps;
  logic [PW-1:0]            clr_idx;
  logic [PW-1:0]            res_path;
  logic                     ecn_f;
  logic                     nack_f;
  logic                     tx_f;
  logic [PW-1:0]            ecn_idx;
  logic [PW-1:0]            nack_idx;
  logic [ENTROPY_W-1:0]     random_tag;
  logic [PERM_CFG_W-1:0]    init_perm;

  // Cursor advance and the paths before and after it.
  logic [PW:0]              cur_inc;
  logic                     wrap;
  logic [PW-1:0]            adv_cursor;
  logic [PW-1:0]            adv_perm;
  logic [PW-1:0]            cur_path;
  logic [PW-1:0]            adv_path;
  logic [PENALTY_WIDTH-1:0] rd_value;
  logic                     rd_zero;
  logic                     next_stop;

  assign cur_inc    = {1'b0, cursor} + (PW + 1)'(1);
  assign wrap       = cur_inc >= NUM_PATHS_EXT;
  assign adv_cursor = wrap ? '0 : cur_inc[PW-1:0];
  assign adv_perm   = wrap ? reshuffle(perm) : perm;
  assign cur_path   = (cursor ^ perm) & IDX_MASK;
  assign adv_path   = (adv_cursor ^ adv_perm) & IDX_MASK;

  // A read that hits the address written in the same cycle takes the new value.
  assign rd_value  = byp_valid ? byp_data : rd_q;
  assign rd_zero   = rd_value == '0;
  assign next_stop = rd_zero || (steps > STEP_LIMIT);

  // Memory port control per command.
  always_comb begin
    rd_addr = cur_path;
    wr_en   = 1'b0;
    wr_addr = cur_path;
    wr_data = '0;
    case (cmd)
      CMD_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
      end
      CMD_ECN_RD: begin
        rd_addr = ecn_idx;
      end
      CMD_ECN_WR: begin
        wr_en   = 1'b1;
        wr_addr = ecn_idx;
        wr_data = rd_value + ECN_INC;
      end
      CMD_NACK_RD: begin
        rd_addr = nack_idx;
      end
      CMD_NACK_WR: begin
        wr_en   = 1'b1;
        wr_addr = nack_idx;
        wr_data = rd_value + NACK_INC;
      end
      CMD_SW_FIRST: begin
        rd_addr = adv_path;
        wr_en   = !rd_zero;
        wr_data = rd_value - PENALTY_WIDTH'(1);
      end
      CMD_SW_NEXT: begin
        rd_addr = adv_path;
      end
      default: begin
      end
    endcase
  end

  // Table storage with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q      <= mem[rd_addr];
    byp_valid <= wr_en && (wr_addr == rd_addr);
    byp_data  <= wr_data;
  end

  // Control state: clear index, cursor, permutation and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      cursor      <= '0;
      perm        <= '0;
      initialized <= 1'b0;
      random_tag  <= '0;
      init_perm   <= '0;
    end else begin
      if (cfg_we && cfg_addr == REG_RANDOM_TAG) begin
        random_tag <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_INIT_PERM) begin
        init_perm <= cfg_wdata[PERM_CFG_W-1:0];
      end
      case (cmd)
        CMD_CLEAR: begin
          clr_idx <= clr_idx + PW'(1);
        end
        CMD_LOAD: begin
          if (!initialized) begin
            perm        <= PW'(ENTROPY_W'(init_perm) & IDX_MASK16);
            initialized <= 1'b1;
          end
        end
        CMD_SW_FIRST: begin
          cursor <= adv_cursor;
          perm   <= adv_perm;
        end
        CMD_SW_NEXT: begin
          if (!next_stop) begin
            cursor <= adv_cursor;
            perm   <= adv_perm;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item latch, sweep bookkeeping and the result beat.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        ecn_f    <= in_flags[0];
        nack_f   <= in_flags[1];
        tx_f     <= in_flags[2];
        ecn_idx  <= PW'(in_data[ENTROPY_W-1:0] & IDX_MASK16);
        nack_idx <= PW'(in_data[2*ENTROPY_W-1:ENTROPY_W] & IDX_MASK16);
      end
      CMD_SW_FIRST: begin
        steps    <= SW'(1);
        res_path <= cur_path;
      end
      CMD_SW_NEXT: begin
        steps    <= steps + SW'(1);
        res_path <= cur_path;
      end
      CMD_EMIT: begin
        out_path     <= tx_f ? (ENTROPY_W'(res_path) | (random_tag & ~IDX_MASK16)) : '0;
        out_flags[0] <= tx_f;
        out_flags[1] <= !(ecn_f || nack_f || tx_f);
      end
      default: begin
      end
    endcase
  end

  assign status.clear_last = clr_idx == IDX_MASK;
  assign status.sweep_done = ((cmd == CMD_SW_FIRST) && rd_zero)
                          || ((cmd == CMD_SW_NEXT) && next_stop);
  assign status.ecn  = ecn_f;
  assign status.nack = nack_f;
  assign status.tx   = tx_f;

endmodule

// File: rtl/core/pmps_ctrl.sv
// Controller: sequences the clearing pass, the table updates, the sweep and the result beat.
module pmps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output pmps_pkg::pmps_cmd_t    cmd,
  input  pmps_pkg::pmps_status_t status
);
  import pmps_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROUTE,
    ST_ECN_RD,
    ST_ECN_WR,
    ST_NACK_RD,
    ST_NACK_WR,
    ST_SW_RD,
    ST_SW_FIRST,
    ST_SW_NEXT,
    ST_EMIT
  } state_t;

  state_t state;
  logic   emit_ok;

  // The result register is free when empty or being drained this cycle.
  assign emit_ok = !m_tvalid || m_tready;

  // Command decode.
  always_comb begin
    case (state)
      ST_CLEAR:    cmd = CMD_CLEAR;
      ST_IDLE:     cmd = s_tvalid ? CMD_LOAD : CMD_NONE;
      ST_ECN_RD:   cmd = CMD_ECN_RD;
      ST_ECN_WR:   cmd = CMD_ECN_WR;
      ST_NACK_RD:  cmd = CMD_NACK_RD;
      ST_NACK_WR:  cmd = CMD_NACK_WR;
      ST_SW_RD:    cmd = CMD_SW_RD;
      ST_SW_FIRST: cmd = CMD_SW_FIRST;
      ST_SW_NEXT:  cmd = CMD_SW_NEXT;
      ST_EMIT:     cmd = emit_ok ? CMD_EMIT : CMD_NONE;
      default:     cmd = CMD_NONE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A drained result clears the valid flag unless a new one is queued in the same cycle.
      if (m_tvalid && m_tready && !(state == ST_EMIT && emit_ok)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state    <= ST_ROUTE;
            s_tready <= 1'b0;
          end
        end
        ST_ROUTE: begin
          if (status.ecn) begin
            state <= ST_ECN_RD;
          end else if (status.nack) begin
            state <= ST_NACK_RD;
          end else if (status.tx) begin
            state <= ST_SW_RD;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_ECN_RD: begin
          state <= ST_ECN_WR;
        end
        ST_ECN_WR: begin
          if (status.nack) begin
            state <= ST_NACK_RD;
          end else if (status.tx) begin
            state <= ST_SW_RD;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_NACK_RD: begin
          state <= ST_NACK_WR;
        end
        ST_NACK_WR: begin
          state <= status.tx ? ST_SW_RD : ST_EMIT;
        end
        ST_SW_RD: begin
          state <= ST_SW_FIRST;
        end
        ST_SW_FIRST: begin
          state <= status.sweep_done ? ST_EMIT : ST_SW_NEXT;
        end
        ST_SW_NEXT: begin
          if (status.sweep_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Input is taken only in the idle state.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input ready outside the idle state");

  // An accepted beat closes the input side until its result is queued.
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_ROUTE && !s_tready)
    else $error("input side still open after an accepted beat");

  // The sweep only finishes in a sweep state.
  a_sweep_done_state: assert property (@(posedge clk) disable iff (rst)
    status.sweep_done |-> (state == ST_SW_FIRST || state == ST_SW_NEXT))
    else $error("sweep finished outside the sweep states");

  // A queued result shows up on the output and the block returns to idle.
  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && emit_ok |=> m_tvalid && state == ST_IDLE && s_tready)
    else $error("result not presented after emit");

endmodule
